/* hdl/cigar_pkg.sv */
// ----------------------------------------------------------------------------
// CIGAR parser package
// Shared payload types and character constants for the CIGAR run-length
// parser.
// ----------------------------------------------------------------------------
package cigar_pkg;

    // Width of the length and total fields on the result channel.
    localparam int RUN_W = 32;

    // ASCII codes the parser reacts to.
    localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
    localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_X    = 8'h58;  // 'X'
    localparam logic [7:0] CHAR_M    = 8'h4D;  // 'M'
    localparam logic [7:0] CHAR_D    = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_I    = 8'h49;  // 'I'

    // One input character.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } t_item;

    // One result: a merged run, or the closing record of a string.
    typedef struct packed {
        logic             run_valid;
        logic [7:0]       run_op;
        logic [RUN_W-1:0] run_length;
        logic             run_last;
        logic [RUN_W-1:0] query_length;
        logic [RUN_W-1:0] target_length;
        logic             overflow;
    } t_result;

endpackage

/* hdl/cigar_run_length_parser_unit.sv */
// ----------------------------------------------------------------------------
// CIGAR run-length parser unit
// Turns a CIGAR text stream into merged runs with query and target totals.
// ----------------------------------------------------------------------------
// The unit takes one character per clock cycle while at most one result is
// queued. Each character is parsed in the cycle it transfers in, and its results
// (none, one or two) are written into a three-entry result queue that drives the
// output channel. The output side delivers one result per cycle while i_out_ready
// is high, so of a character that yields two results (an operation change on the
// last character) the second waits in the queue; the input is ready whenever at
// most one result is queued. Digits accumulate a decimal count, '=' and 'X' are
// folded to 'M', equal adjacent operations are merged, and counts and totals
// saturate at min(2^COUNT_WIDTH - 1, 2^32 - 1) with the overflow flag raised.
module cigar_run_length_parser_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cigar_pkg::t_item    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cigar_pkg::t_result  o_out_data
);
    import cigar_pkg::*;

    // Internal count width: saturation never goes past 32 bits.
    localparam int CW      = (COUNT_WIDTH < RUN_W) ? COUNT_WIDTH : RUN_W;
    localparam int Q_DEPTH = 3;

    // Parser state.
    logic          r_pv,  n_pv;
    logic [7:0]    r_op,  n_op;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_q,   n_q;
    logic [CW-1:0] r_t,   n_t;
    logic          r_ovf, n_ovf;

    // Result queue; slot 0 is the head.
    t_result       r_slot [Q_DEPTH];
    t_result       n_slot [Q_DEPTH];
    t_result       shifted [Q_DEPTH];
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    cnt_ap;

    logic          in_xfer, out_xfer;
    logic          is_digit, emit_prev;
    logic [1:0]    n_res;
    logic [7:0]    op_fold;
    logic [CW-1:0] run_cnt;
    logic [CW+3:0] acc_x10;
    logic [CW:0]   len_sum, q_sum, t_sum;
    t_result       res_prev, res_last, res0, res1;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt <= 2'd1);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[0];

    // Character decode and the arithmetic on counts and totals.
    assign is_digit = (i_in_data.char_code >= CHAR_ZERO) && (i_in_data.char_code <= CHAR_NINE);
    assign op_fold  = ((i_in_data.char_code == CHAR_EQ) || (i_in_data.char_code == CHAR_X))
                      ? CHAR_M : i_in_data.char_code;
    assign run_cnt  = (r_acc == '0) ? CW'(1) : r_acc;
    assign acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + (CW+4)'(i_in_data.char_code - CHAR_ZERO);
    assign len_sum  = {1'b0, r_len} + {1'b0, run_cnt};
    assign q_sum    = {1'b0, r_q} + {1'b0, run_cnt};
    assign t_sum    = {1'b0, r_t} + {1'b0, run_cnt};

    // Next parser state and the results of the current character.
    always_comb begin
        n_pv      = r_pv;
        n_op      = r_op;
        n_len     = r_len;
        n_acc     = r_acc;
        n_q       = r_q;
        n_t       = r_t;
        n_ovf     = r_ovf;
        emit_prev = 1'b0;
        if (is_digit) begin
            if (acc_x10[CW+3:CW] != '0) begin
                n_acc = '1;
                n_ovf = 1'b1;
            end else begin
                n_acc = acc_x10[CW-1:0];
            end
        end else begin
            if (r_pv && (op_fold == r_op)) begin
                if (len_sum[CW]) begin
                    n_len = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_len = len_sum[CW-1:0];
                end
            end else begin
                emit_prev = r_pv;
                n_pv      = 1'b1;
                n_op      = op_fold;
                n_len     = run_cnt;
            end
            if (op_fold != CHAR_D) begin
                if (q_sum[CW]) begin
                    n_q   = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_q = q_sum[CW-1:0];
                end
            end
            if (op_fold != CHAR_I) begin
                if (t_sum[CW]) begin
                    n_t   = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_t = t_sum[CW-1:0];
                end
            end
            n_acc = '0;
        end

        // The run closed by an operation change carries no totals.
        res_prev.run_valid     = 1'b1;
        res_prev.run_op        = r_op;
        res_prev.run_length    = RUN_W'(r_len);
        res_prev.run_last      = 1'b0;
        res_prev.query_length  = '0;
        res_prev.target_length = '0;
        res_prev.overflow      = r_ovf;

        // The closing record; an empty string leaves the run fields zero.
        res_last.run_valid     = n_pv;
        res_last.run_op        = n_op;
        res_last.run_length    = RUN_W'(n_len);
        res_last.run_last      = 1'b1;
        res_last.query_length  = RUN_W'(n_q);
        res_last.target_length = RUN_W'(n_t);
        res_last.overflow      = n_ovf;

        res0  = emit_prev ? res_prev : res_last;
        res1  = res_last;
        n_res = in_xfer ? ({1'b0, emit_prev} + {1'b0, i_in_data.end_of_string}) : 2'd0;

        // The end of a string clears everything for the next one.
        if (i_in_data.end_of_string) begin
            n_pv  = 1'b0;
            n_op  = '0;
            n_len = '0;
            n_acc = '0;
            n_q   = '0;
            n_t   = '0;
            n_ovf = 1'b0;
        end
    end

    // Queue update: drop the head on an output transfer, then append.
    always_comb begin
        cnt_ap = r_cnt - {1'b0, out_xfer};
        for (int i = 0; i < Q_DEPTH - 1; i++) begin
            shifted[i] = out_xfer ? r_slot[i+1] : r_slot[i];
        end
        shifted[Q_DEPTH-1] = r_slot[Q_DEPTH-1];
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (2'(i) < cnt_ap) begin
                n_slot[i] = shifted[i];
            end else if (2'(i) == cnt_ap) begin
                n_slot[i] = res0;
            end else begin
                n_slot[i] = res1;
            end
        end
        n_cnt = cnt_ap + n_res;
    end

    // Control state and parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_pv  <= 1'b0;
            r_op  <= '0;
            r_len <= '0;
            r_acc <= '0;
            r_q   <= '0;
            r_t   <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (in_xfer) begin
                r_pv  <= n_pv;
                r_op  <= n_op;
                r_len <= n_len;
                r_acc <= n_acc;
                r_q   <= n_q;
                r_t   <= n_t;
                r_ovf <= n_ovf;
            end
        end
    end

    // Result queue payload.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    // A character only transfers when the queue can take two results.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_cnt <= 2'd1))
        else $error("character transferred with no room for two results");

    // The end of a string leaves the parser cleared.
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.end_of_string) |=>
            (!r_pv && (r_acc == '0) && (r_q == '0) && (r_t == '0) && !r_ovf))
        else $error("parser state not cleared after end of string");

    // A pending run always has a nonzero length.
    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_len != '0))
        else $error("pending run with zero length");

    // Runs that are not last carry no totals.
    a_mid_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.run_last) |->
            (o_out_data.run_valid && (o_out_data.query_length == '0)
             && (o_out_data.target_length == '0)))
        else $error("intermediate run carries totals");

endmodule
